>>> rtl/ost_pkg.sv
// Shared types, constants and triangle tables for the octant surface triangulator.
package ost_pkg;

   localparam int NUM_TRI    = 12;
   localparam int TRI_CNT_W  = 4;
   localparam int DEPTH_CAP  = 30;
   localparam int DEPTH_W    = 5;
   localparam int ANCHOR_W   = 30;
   localparam int SIDE_W     = 31;
   localparam int EXTENT_W   = 31;
   localparam int COORD_W    = 32;
   localparam int GRID_W     = 32;
   localparam int DIFF_W     = GRID_W + 1;
   localparam int PROD_W     = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [TRI_CNT_W-1:0] TRI_LAST = TRI_CNT_W'(NUM_TRI - 1);

   typedef enum logic [2:0] {
      REG_ORIGIN_X   = 3'd0,
      REG_ORIGIN_Y   = 3'd1,
      REG_ORIGIN_Z   = 3'd2,
      REG_EXTENT_X   = 3'd3,
      REG_EXTENT_Y   = 3'd4,
      REG_EXTENT_Z   = 3'd5,
      REG_TREE_DEPTH = 3'd6
   } csr_index_type;

   typedef logic [2:0] corner_type;
   typedef logic [2:0] normal_type;

   // Corner bit d selects the far side of the octant on axis d.
   localparam corner_type TRI_CORNER [NUM_TRI][3] = '{
      '{3'd0, 3'd1, 3'd5}, '{3'd0, 3'd5, 3'd4}, '{3'd0, 3'd4, 3'd6},
      '{3'd0, 3'd6, 3'd2}, '{3'd0, 3'd2, 3'd3}, '{3'd0, 3'd3, 3'd1},
      '{3'd5, 3'd1, 3'd7}, '{3'd4, 3'd5, 3'd7}, '{3'd6, 3'd4, 3'd7},
      '{3'd2, 3'd6, 3'd7}, '{3'd3, 3'd2, 3'd7}, '{3'd1, 3'd3, 3'd7}
   };

   localparam normal_type TRI_NORMAL [NUM_TRI] = '{
      3'd2, 3'd2, 3'd0, 3'd0, 3'd4, 3'd4, 3'd1, 3'd5, 3'd5, 3'd3, 3'd3, 3'd1
   };

   typedef struct packed {
      logic [ANCHOR_W-1:0] anchor_x;
      logic [ANCHOR_W-1:0] anchor_y;
      logic [ANCHOR_W-1:0] anchor_z;
      logic [SIDE_W-1:0]   side_len;
   } req_type;

   typedef struct packed {
      normal_type                 normal_code;
      logic signed [COORD_W-1:0]  p0_x;
      logic signed [COORD_W-1:0]  p0_y;
      logic signed [COORD_W-1:0]  p0_z;
      logic signed [COORD_W-1:0]  p1_x;
      logic signed [COORD_W-1:0]  p1_y;
      logic signed [COORD_W-1:0]  p1_z;
      logic signed [COORD_W-1:0]  p2_x;
      logic signed [COORD_W-1:0]  p2_y;
      logic signed [COORD_W-1:0]  p2_z;
      logic                       last_tri;
   } rsp_type;

endpackage

>>> rtl/octant_surface_triangulator_core.sv
// Octant to triangle mesh core: corner mapping pipeline, triangle sequencer and registers.
//
// One octant is taken per start/busy transaction and turned into the 12 triangles of its
// surface, which leave on rsp_data one per clock, each marked by rsp_valid for a single
// cycle; the receiver cannot stall, so it must take every triangle as it comes. The first
// triangle leaves through the mapping pipeline and the world and result registers; the last
// one is flagged by last_tri. busy is raised after each acceptance to hold off the next
// octant, at a pace set by the result port moving one triangle per clock; the next
// octant runs through the 4-stage mapping pipeline while the current run is still on
// the result port. Corner coordinates are mapped to world Q16.16 with round to nearest
// (ties upward) and saturate to 32 bits. Write the registers only while the block is
// idle; pready is always high and reads return the stored values.
module octant_surface_triangulator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  ost_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output ost_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ost_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ost_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ost_pkg::CSR_DATA_W-1:0] prdata,
   output logic                        pready
);
   import ost_pkg::*;

   // configuration registers
   logic signed [COORD_W-1:0]  origin_ff [3];
   logic [EXTENT_W-1:0]        extent_ff [3];
   logic [DEPTH_W-1:0]         depth_ff;
   logic [DEPTH_W-1:0]         depth_eff;
   logic [GRID_W-1:0]          half;
   logic                       csr_wr;
   csr_index_type              csr_idx;

   // intake and pipeline
   logic                       accept;
   logic [TRI_CNT_W-1:0]       gap_ff;
   req_type                    req_ff;
   logic                       in_vld_ff, diff_vld_ff, prod_vld_ff, quo_vld_ff;
   logic [ANCHOR_W-1:0]        anchor [3];
   logic [GRID_W-1:0]          grid [2][3];
   logic signed [DIFF_W-1:0]   diff_in [2][3];
   logic signed [DIFF_W-1:0]   diff_ff [2][3];
   logic signed [PROD_W:0]     prod_full [2][3];
   logic signed [PROD_W-1:0]   prod_in [2][3];
   logic signed [PROD_W-1:0]   prod_ff [2][3];
   logic signed [PROD_W-1:0]   quo_in [2][3];
   logic signed [PROD_W-1:0]   quo_ff [2][3];
   logic signed [PROD_W-1:0]   wsum [2][3];
   logic signed [COORD_W-1:0]  world_in [2][3];
   logic signed [COORD_W-1:0]  world_ff [2][3];

   // triangle sequencer and result register
   logic                       active_ff, active_in;
   logic [TRI_CNT_W-1:0]       tri_ff, tri_in;
   logic signed [COORD_W-1:0]  vert [3][3];
   rsp_type                    rsp_in, rsp_ff;
   logic                       rsp_valid_ff;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < 3; d++) begin
            origin_ff[d] <= '0;
            extent_ff[d] <= EXTENT_W'(65536);
         end
         depth_ff <= DEPTH_W'(DEPTH_CAP);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ORIGIN_X:   origin_ff[0] <= pwdata;
            REG_ORIGIN_Y:   origin_ff[1] <= pwdata;
            REG_ORIGIN_Z:   origin_ff[2] <= pwdata;
            REG_EXTENT_X:   extent_ff[0] <= pwdata[EXTENT_W-1:0];
            REG_EXTENT_Y:   extent_ff[1] <= pwdata[EXTENT_W-1:0];
            REG_EXTENT_Z:   extent_ff[2] <= pwdata[EXTENT_W-1:0];
            REG_TREE_DEPTH: depth_ff     <= pwdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ORIGIN_X:   prdata = origin_ff[0];
         REG_ORIGIN_Y:   prdata = origin_ff[1];
         REG_ORIGIN_Z:   prdata = origin_ff[2];
         REG_EXTENT_X:   prdata = CSR_DATA_W'(extent_ff[0]);
         REG_EXTENT_Y:   prdata = CSR_DATA_W'(extent_ff[1]);
         REG_EXTENT_Z:   prdata = CSR_DATA_W'(extent_ff[2]);
         REG_TREE_DEPTH: prdata = CSR_DATA_W'(depth_ff);
         default:        prdata = '0;
      endcase
   end

   // clamp depth into the supported range
   always_comb begin
      priority if (depth_ff == '0)
         depth_eff = DEPTH_W'(1);
      else if (depth_ff > DEPTH_W'(DEPTH_CAP))
         depth_eff = DEPTH_W'(DEPTH_CAP);
      else
         depth_eff = depth_ff;
   end

   assign half = GRID_W'(1) << (depth_eff - DEPTH_W'(1));

   // ---------------- intake ----------------
   assign accept = start && !busy;
   assign busy   = (gap_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else if (accept) begin
         gap_ff <= TRI_LAST;
      end else if (gap_ff != '0) begin
         gap_ff <= gap_ff - TRI_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         diff_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         quo_vld_ff  <= 1'b0;
      end else begin
         in_vld_ff   <= accept;
         diff_vld_ff <= in_vld_ff;
         prod_vld_ff <= diff_vld_ff;
         quo_vld_ff  <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // ---------------- stage 1: corner coordinates, offset from grid center ----------------
   assign anchor[0] = req_ff.anchor_x;
   assign anchor[1] = req_ff.anchor_y;
   assign anchor[2] = req_ff.anchor_z;

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         grid[0][d] = GRID_W'(anchor[d]);
         grid[1][d] = GRID_W'(anchor[d]) + GRID_W'(req_ff.side_len);
         for (int h = 0; h < 2; h++) begin
            diff_in[h][d] = $signed({1'b0, grid[h][d]}) - $signed({1'b0, half});
         end
      end
   end

   // ---------------- stage 2: scale by extent ----------------
   always_comb begin
      for (int h = 0; h < 2; h++) begin
         for (int d = 0; d < 3; d++) begin
            prod_full[h][d] = diff_ff[h][d] * $signed({1'b0, extent_ff[d]});
            prod_in[h][d]   = $signed(prod_full[h][d][PROD_W-1:0]);
         end
      end
   end

   // ---------------- stage 3: round and divide by grid size ----------------
   always_comb begin
      for (int h = 0; h < 2; h++) begin
         for (int d = 0; d < 3; d++) begin
            quo_in[h][d] = (prod_ff[h][d] + $signed({{(PROD_W-GRID_W){1'b0}}, half}))
                           >>> depth_eff;
         end
      end
   end

   // ---------------- stage 4: add origin and saturate ----------------
   always_comb begin
      for (int h = 0; h < 2; h++) begin
         for (int d = 0; d < 3; d++) begin
            wsum[h][d] = quo_ff[h][d] + PROD_W'(origin_ff[d]);
            priority if (&wsum[h][d][PROD_W-1:COORD_W-1] || ~|wsum[h][d][PROD_W-1:COORD_W-1])
               world_in[h][d] = $signed(wsum[h][d][COORD_W-1:0]);
            else if (wsum[h][d][PROD_W-1])
               world_in[h][d] = {1'b1, {(COORD_W-1){1'b0}}};
            else
               world_in[h][d] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      if (quo_vld_ff) begin
         world_ff <= world_in;
      end
   end

   // ---------------- triangle sequencer ----------------
   always_comb begin
      active_in = active_ff;
      tri_in    = tri_ff;
      if (quo_vld_ff) begin
         active_in = 1'b1;
         tri_in    = '0;
      end else if (active_ff) begin
         if (tri_ff == TRI_LAST) begin
            active_in = 1'b0;
            tri_in    = '0;
         end else begin
            tri_in = tri_ff + TRI_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         tri_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         tri_ff       <= tri_in;
         rsp_valid_ff <= active_ff;
      end
   end

   // pick each vertex coordinate from the low or high side per corner bit
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int d = 0; d < 3; d++) begin
            vert[k][d] = world_ff[TRI_CORNER[tri_ff][k][d]][d];
         end
      end
      rsp_in.normal_code = TRI_NORMAL[tri_ff];
      rsp_in.p0_x        = vert[0][0];
      rsp_in.p0_y        = vert[0][1];
      rsp_in.p0_z        = vert[0][2];
      rsp_in.p1_x        = vert[1][0];
      rsp_in.p1_y        = vert[1][1];
      rsp_in.p1_z        = vert[1][2];
      rsp_in.p2_x        = vert[2][0];
      rsp_in.p2_y        = vert[2][1];
      rsp_in.p2_z        = vert[2][2];
      rsp_in.last_tri    = (tri_ff == TRI_LAST);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- assertions ----------------
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0({in_vld_ff, diff_vld_ff, prod_vld_ff, quo_vld_ff}))
      else $error("more than one octant in the mapping pipeline");

   a_sequencer_free: assert property (@(posedge clock) disable iff (reset)
      quo_vld_ff |-> (!active_ff || tri_ff == TRI_LAST))
      else $error("mapped octant arrives while a triangle run is still in progress");

   a_run_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last_tri) |=> rsp_valid_ff)
      else $error("triangle run broken before its last triangle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an accepted transaction");

endmodule
